>>> src/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the stable priority queue drain block.
// No dependencies.
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int VALUE_WIDTH = 16;
	localparam int PRIO_W      = 10;

	localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(999);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SERVE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_SERVED  = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic        [PRIO_W-1:0]      prio;
	} entry_t;

	typedef struct packed {
		logic   vld;
		entry_t e;
	} slot_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
		sat_prio = (p > PRIO_MAX) ? PRIO_MAX : p;
	endfunction

endpackage

>>> src/spq_in_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready transfer of one opcode, value and priority.
// Depends on spq_pkg.
interface spq_in_if import spq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [VALUE_WIDTH-1:0] value;
	logic        [PRIO_W-1:0]      priority_req;

	modport source (output valid, opcode, value, priority_req, input ready);
	modport sink   (input valid, opcode, value, priority_req, output ready);
endinterface

>>> src/spq_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready transfer of one served entry or status result.
// Depends on spq_pkg.
interface spq_out_if import spq_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] out_value;
	logic        [PRIO_W-1:0]      out_priority;
	logic        [1:0]             status;
	logic                          last;

	modport source (output valid, out_value, out_priority, status, last, input ready);
	modport sink   (input valid, out_value, out_priority, status, last, output ready);
endinterface

>>> src/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted shift chain: takes the new entry or its left neighbor on
// insert, its right neighbor on drain. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_e,
	input  slot_t     left,
	input  logic      left_take,
	input  slot_t     right,
	output slot_t     own,
	output logic      take
);

	logic   own_vld_q;
	entry_t own_e_q;
	slot_t  nxt;

	assign take = ctl.insert && (!own_vld_q || (new_e.prio < own_e_q.prio));
	assign own  = {own_vld_q, own_e_q};

	always_comb begin
		nxt = {own_vld_q, own_e_q};
		if (ctl.shift) begin
			nxt = right;
		end else if (take) begin
			if (left_take) begin
				nxt = left;
			end else begin
				nxt.vld = 1'b1;
				nxt.e   = new_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_vld_q <= 1'b0;
		end else begin
			own_vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		own_e_q <= nxt.e;
	end

endmodule

>>> src/stable_priority_queue_drain_core.sv
`timescale 1ns / 1ps
// Stable priority queue: a chain of QUEUE_DEPTH cells kept sorted by priority on insert.
// Insert: one per cycle unless draining or output stalls; full yields a dropped result.
// Serve: all entries, one result per cycle from the head cell unless the output stalls.
// Reset clears the cell valid bits, drain flag and output valid; payloads are not cleared.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
module stable_priority_queue_drain_core import spq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	spq_in_if.sink  req,
	spq_out_if.source rsp
);

	slot_t                  slot [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] take;
	logic [QUEUE_DEPTH-1:0] vld_vec;
	cell_ctl_t              ctl;
	entry_t                 new_e;

	logic drain_q;
	logic rsp_vld_q;
	entry_t  rsp_e_q;
	status_t rsp_st_q;
	logic    rsp_last_q;

	logic can_load, acc, is_ins, is_srv, full, empty, drain_step;

	assign can_load   = !rsp_vld_q || rsp.ready;
	assign req.ready  = !drain_q && can_load;
	assign acc        = req.valid && req.ready;
	assign is_ins     = acc && (req.opcode == OP_INSERT);
	assign is_srv     = acc && (req.opcode == OP_SERVE);
	assign full       = vld_vec[QUEUE_DEPTH-1];
	assign empty      = !vld_vec[0];
	assign drain_step = drain_q && can_load;

	assign ctl.insert = is_ins && !full;
	assign ctl.shift  = drain_step;
	assign new_e.value = req.value;
	assign new_e.prio  = sat_prio(req.priority_req);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_t l_slot, r_slot;
		logic  l_take;
		if (i == 0) begin : g_head
			assign l_slot = '0;
			assign l_take = 1'b0;
		end else begin : g_body
			assign l_slot = slot[i-1];
			assign l_take = take[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_slot = '0;
		end else begin : g_mid
			assign r_slot = slot[i+1];
		end
		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_e     (new_e),
			.left      (l_slot),
			.left_take (l_take),
			.right     (r_slot),
			.own       (slot[i]),
			.take      (take[i])
		);
		assign vld_vec[i] = slot[i].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (drain_step) begin
				drain_q <= vld_vec[1];
			end else if (is_srv && !empty) begin
				drain_q <= 1'b1;
			end
			if (drain_step || (is_ins && full) || (is_srv && empty)) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			rsp_e_q    <= slot[0].e;
			rsp_st_q   <= ST_SERVED;
			rsp_last_q <= !vld_vec[1];
		end else if (is_ins && full) begin
			rsp_e_q    <= '0;
			rsp_st_q   <= ST_DROPPED;
			rsp_last_q <= 1'b1;
		end else if (is_srv && empty) begin
			rsp_e_q    <= '0;
			rsp_st_q   <= ST_EMPTY;
			rsp_last_q <= 1'b1;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.out_value    = rsp_e_q.value;
	assign rsp.out_priority = rsp_e_q.prio;
	assign rsp.status       = rsp_st_q;
	assign rsp.last         = rsp_last_q;

	a_vld_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec & (vld_vec + QUEUE_DEPTH'(1))) == '0))
		else $error("cell valid bits not packed at the head");

	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> vld_vec[0])
		else $error("drain active with empty head cell");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drain_q) |-> (vld_vec == '0))
		else $error("entries left after drain");

endmodule
